>>> src/ms_adpcm_block_decoder_core_macros.svh
// ============================================================================
// ms_adpcm_block_decoder_core_macros.svh
// Assertion macros shared by the ADPCM block decoder RTL.
// ============================================================================
`ifndef MS_ADPCM_BLOCK_DECODER_CORE_MACROS_SVH
`define MS_ADPCM_BLOCK_DECODER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSADPCM_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("msadpcm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MSADPCM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("msadpcm assertion failed");

`endif

>>> src/msadpcm_pkg.sv
// ============================================================================
// msadpcm_pkg
// Shared types, register indexes and tables of the ADPCM block decoder.
// ============================================================================
package msadpcm_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned SPB_W    = 14;
    localparam int unsigned CFG_W    = 64;

    localparam logic [15:0] STEP_FLOOR = 16'd16;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_CHANNEL_COUNT     = 3'd0,
        CFG_SAMPLES_PER_BLOCK = 3'd1,
        CFG_COEF_COUNT        = 3'd2,
        CFG_COEF_SETS_0_1     = 3'd3,
        CFG_COEF_SETS_2_3     = 3'd4,
        CFG_COEF_SETS_4_5     = 3'd5,
        CFG_COEF_SET_6        = 3'd6
    } cfg_index_t;

    // Operands of one nibble decode.
    typedef struct packed {
        logic [3:0]         nib;
        logic [15:0]        step_size;
        logic signed [15:0] hist_one;
        logic signed [15:0] hist_two;
        logic signed [15:0] coef_one;
        logic signed [15:0] coef_two;
    } dec_req_t;

    typedef struct packed {
        logic [15:0]        step_size;
        logic signed [15:0] sample;
    } dec_rsp_t;

    // Step adaptation factor, in 1/256 units.
    function automatic logic [9:0] adapt_factor(input logic [3:0] nib);
        logic [9:0] f;
        case (nib)
            4'd0, 4'd1, 4'd2, 4'd3:  f = 10'd230;
            4'd4:                    f = 10'd307;
            4'd5:                    f = 10'd409;
            4'd6:                    f = 10'd512;
            4'd7:                    f = 10'd614;
            4'd8:                    f = 10'd768;
            4'd9:                    f = 10'd614;
            4'd10:                   f = 10'd512;
            4'd11:                   f = 10'd409;
            4'd12:                   f = 10'd307;
            default:                 f = 10'd230;
        endcase
        return f;
    endfunction

endpackage

>>> src/msadpcm_nibble.sv
// ============================================================================
// msadpcm_nibble
// Decodes one 4-bit code: step adaptation, two-tap prediction and clamping.
// ============================================================================
module msadpcm_nibble (
    input  msadpcm_pkg::dec_req_t req,
    output msadpcm_pkg::dec_rsp_t rsp
);

    logic [9:0]         factor;
    logic [25:0]        step_prod;
    logic [17:0]        step_raw;
    logic signed [20:0] scaled;
    logic signed [31:0] prod_one;
    logic signed [31:0] prod_two;
    logic signed [32:0] pred_sum;
    logic signed [24:0] pred;
    logic signed [25:0] total;

    assign factor    = msadpcm_pkg::adapt_factor(req.nib);
    assign step_prod = 26'(factor) * 26'(req.step_size);
    assign step_raw  = step_prod[25:8];

    always_comb begin
        if (step_raw[17:16] != 2'b00) begin
            rsp.step_size = 16'hffff;
        end else if (step_raw[15:0] < msadpcm_pkg::STEP_FLOOR) begin
            rsp.step_size = msadpcm_pkg::STEP_FLOOR;
        end else begin
            rsp.step_size = step_raw[15:0];
        end
    end

    // The code is a signed nibble scaled by the step before adaptation.
    assign scaled   = 21'($signed(req.nib)) * $signed({5'd0, req.step_size});
    assign prod_one = $signed(req.hist_one) * $signed(req.coef_one);
    assign prod_two = $signed(req.hist_two) * $signed(req.coef_two);
    assign pred_sum = 33'(prod_one) + 33'(prod_two);
    // Arithmetic shift gives the floor of the division by 256.
    assign pred     = pred_sum[32:8];
    assign total    = 26'(scaled) + 26'(pred);

    always_comb begin
        if (total > 26'sd32767) begin
            rsp.sample = 16'sh7fff;
        end else if (total < -26'sd32768) begin
            rsp.sample = 16'sh8000;
        end else begin
            rsp.sample = total[15:0];
        end
    end

endmodule

>>> src/ms_adpcm_block_decoder_core.sv
// ============================================================================
// ms_adpcm_block_decoder_core
// Block decoder for 4-bit ADPCM in the common two-tap format, mono or stereo.
// ============================================================================
// Bytes of a compressed block enter on the s_axis channel, one item per byte,
// with tuser marking the first byte of a block. Decoded samples leave on the
// m_axis channel, one item per sample, with tlast on the last sample caused
// by an input byte. Coefficients, channel count, coefficient count and block
// length are written through the cfg channel; the user must write them only
// while the decoder is idle, which the block itself does not enforce.
// A byte is held in an input register and produces one sample per cycle from
// there into the output register while the receiver takes them: a data byte
// gives two samples (its two nibbles), the last of an odd mono block one, the
// last header byte two in mono and four in stereo, every other byte none. The
// next byte is accepted in the cycle its predecessor produces its last sample.
// Both nibbles go through the single nibble decoder, which is shared because
// a mono byte's second nibble needs the first one's result.
// A stalled receiver holds the output register and, through it, the input
// register; nothing is lost. Reset returns all but the payload registers to
// their defaults and leaves no block active.
// ============================================================================
`include "ms_adpcm_block_decoder_core_macros.svh"

module ms_adpcm_block_decoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] block_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] pcm_sample
    output logic [2:0]  m_axis_tuser,   // [0] channel_index, [1] from_header, [2] bad_predictor
    output logic        m_axis_tlast,   // last_in_run
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    // Configuration registers.
    logic [1:0]  chan_cnt_reg;
    logic [13:0] spb_reg;
    logic [2:0]  coef_cnt_reg;
    logic [63:0] coef_reg [3];
    logic [31:0] coef6_reg;

    // Decoder state.
    logic [2:0]  pred_reg [2];
    logic [15:0] step_reg [2];
    logic [15:0] h1_reg [2];
    logic [15:0] h2_reg [2];
    logic [3:0]  hbc_reg;
    logic [13:0] rem_reg;
    logic [7:0]  low_reg;
    logic [1:0]  bad_reg;
    logic        active_reg;
    logic        stereo_reg;

    logic [2:0]  pred_next [2];
    logic [15:0] step_next [2];
    logic [15:0] h1_next [2];
    logic [15:0] h2_next [2];
    logic [3:0]  hbc_next;
    logic [13:0] rem_next;
    logic [7:0]  low_next;
    logic [1:0]  bad_next;
    logic        active_next;
    logic        stereo_next;

    // Item held in the input register and its result sequencing.
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_start_reg;
    logic [1:0]  ph_reg;
    logic [1:0]  last_k_reg;
    logic        hdr_item_reg;
    logic [1:0]  ph_next;

    // Output register.
    logic        m_valid_reg;
    logic [15:0] m_pcm_reg;
    logic        m_ch_reg;
    logic        m_hdr_reg;
    logic        m_bad_reg;
    logic        m_last_reg;

    // Phase-zero decode of the held byte.
    logic        out_free;
    logic        step_en;
    logic        active_eff;
    logic        stereo_eff;
    logic [3:0]  hbc_eff;
    logic [13:0] rem_eff;
    logic [3:0]  hlen;
    logic [3:0]  nch;
    logic        in_header;
    logic        hdr_last;
    logic        is_pred;
    logic [3:0]  rel;
    logic [1:0]  wr_field;
    logic        wr_ch;
    logic [15:0] wr_value;
    logic [2:0]  cnt_eff;
    logic [2:0]  n0;
    logic [13:0] rem_data;
    logic        item_done;
    logic        emit;

    // Nibble decode.
    logic                  data_res;
    logic                  dec_ch;
    logic [2:0]            pset;
    logic [31:0]           coef_pair;
    msadpcm_pkg::dec_req_t dec_req;
    msadpcm_pkg::dec_rsp_t dec_rsp;

    // Header result selection.
    logic        hdr_ch;
    logic        hdr_use_h1;
    logic [15:0] hdr_value;

    logic [15:0] res_pcm;
    logic        res_ch;
    logic        res_last;

    assign cfg_ready     = 1'b1;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign step_en       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || (step_en && item_done);

    // ---------------------------------------------------------------- header
    assign active_eff = in_start_reg || active_reg;
    assign stereo_eff = in_start_reg ? (chan_cnt_reg >= 2'd2) : stereo_reg;
    assign hbc_eff    = in_start_reg ? 4'd0 : hbc_reg;
    assign rem_eff    = in_start_reg ? 14'd0 : rem_reg;
    assign nch        = stereo_eff ? 4'd2 : 4'd1;
    assign hlen       = stereo_eff ? 4'd14 : 4'd7;
    assign in_header  = hbc_eff < hlen;
    assign hdr_last   = hbc_eff == (hlen - 4'd1);
    assign is_pred    = hbc_eff < nch;
    assign rel        = hbc_eff - nch;
    assign wr_field   = stereo_eff ? rel[3:2] : rel[2:1];
    assign wr_ch      = stereo_eff ? rel[1] : 1'b0;
    assign wr_value   = {in_byte_reg, low_reg};
    assign cnt_eff    = (coef_cnt_reg == 3'd0) ? 3'd1 : coef_cnt_reg;

    always_comb begin
        rem_data = 14'd0;
        if (!active_eff) begin
            n0 = 3'd0;
        end else if (in_header) begin
            n0 = hdr_last ? (stereo_eff ? 3'd4 : 3'd2) : 3'd0;
        end else if (rem_eff == 14'd0) begin
            n0 = 3'd0;
        end else if (stereo_eff) begin
            n0       = 3'd2;
            rem_data = rem_eff - 14'd1;
        end else if (rem_eff >= 14'd2) begin
            n0       = 3'd2;
            rem_data = rem_eff - 14'd2;
        end else begin
            // Last mono sample of an odd block: high nibble only.
            n0 = 3'd1;
        end
    end

    assign item_done = (ph_reg == 2'd0) ? (n0 <= 3'd1) : (ph_reg == last_k_reg);
    assign emit      = step_en && ((ph_reg != 2'd0) || (n0 != 3'd0));
    assign res_last  = (ph_reg == 2'd0) ? (n0 == 3'd1) : (ph_reg == last_k_reg);

    // ---------------------------------------------------------------- decode
    assign data_res = (ph_reg == 2'd0) ? (active_eff && !in_header && rem_eff != 14'd0)
                                       : !hdr_item_reg;
    assign dec_ch   = (ph_reg == 2'd0) ? 1'b0 : stereo_reg;
    assign pset     = pred_reg[dec_ch];

    always_comb begin
        case (pset[2:1])
            2'd0:    coef_pair = pset[0] ? coef_reg[0][63:32] : coef_reg[0][31:0];
            2'd1:    coef_pair = pset[0] ? coef_reg[1][63:32] : coef_reg[1][31:0];
            2'd2:    coef_pair = pset[0] ? coef_reg[2][63:32] : coef_reg[2][31:0];
            default: coef_pair = coef6_reg;
        endcase
    end

    assign dec_req.nib       = (ph_reg == 2'd0) ? in_byte_reg[7:4] : in_byte_reg[3:0];
    assign dec_req.step_size = step_reg[dec_ch];
    assign dec_req.hist_one  = h1_reg[dec_ch];
    assign dec_req.hist_two  = h2_reg[dec_ch];
    assign dec_req.coef_one  = coef_pair[15:0];
    assign dec_req.coef_two  = coef_pair[31:16];

    msadpcm_nibble u_nibble (
        .req (dec_req),
        .rsp (dec_rsp)
    );

    // Header results: history two of each channel, then history one.
    assign hdr_ch     = stereo_eff ? ph_reg[0] : 1'b0;
    assign hdr_use_h1 = stereo_eff ? ph_reg[1] : ph_reg[0];

    always_comb begin
        if (hdr_use_h1) begin
            hdr_value = h1_reg[hdr_ch];
        end else if (ph_reg == 2'd0 && wr_ch == hdr_ch) begin
            // The byte in hand completes this very history value.
            hdr_value = wr_value;
        end else begin
            hdr_value = h2_reg[hdr_ch];
        end
    end

    assign res_pcm = data_res ? dec_rsp.sample : hdr_value;
    assign res_ch  = data_res ? dec_ch : hdr_ch;

    // ---------------------------------------------------------- state update
    always_comb begin
        pred_next   = pred_reg;
        step_next   = step_reg;
        h1_next     = h1_reg;
        h2_next     = h2_reg;
        hbc_next    = hbc_reg;
        rem_next    = rem_reg;
        low_next    = low_reg;
        bad_next    = bad_reg;
        active_next = active_reg;
        stereo_next = stereo_reg;
        ph_next     = ph_reg;

        if (step_en) begin
            ph_next = item_done ? 2'd0 : ph_reg + 2'd1;
        end

        if (step_en && ph_reg == 2'd0 && active_eff) begin
            active_next = 1'b1;
            stereo_next = stereo_eff;
            hbc_next    = hbc_eff;
            rem_next    = rem_eff;
            if (in_start_reg) begin
                bad_next = 2'b00;
            end
            if (in_header) begin
                if (is_pred) begin
                    if (in_byte_reg >= {5'd0, cnt_eff}) begin
                        bad_next[hbc_eff[0]]  = 1'b1;
                        pred_next[hbc_eff[0]] = cnt_eff - 3'd1;
                    end else begin
                        pred_next[hbc_eff[0]] = in_byte_reg[2:0];
                    end
                end else if (!rel[0]) begin
                    low_next = in_byte_reg;
                end else begin
                    case (wr_field)
                        2'd0:    step_next[wr_ch] = wr_value;
                        2'd1:    h1_next[wr_ch]   = wr_value;
                        default: h2_next[wr_ch]   = wr_value;
                    endcase
                end
                hbc_next = hbc_eff + 4'd1;
                if (hdr_last) begin
                    rem_next = (spb_reg >= 14'd2) ? spb_reg - 14'd2 : 14'd0;
                end
            end else begin
                rem_next = rem_data;
            end
        end

        if (step_en && data_res) begin
            step_next[dec_ch] = dec_rsp.step_size;
            h2_next[dec_ch]   = h1_reg[dec_ch];
            h1_next[dec_ch]   = dec_rsp.sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_cnt_reg <= 2'd1;
            spb_reg      <= 14'd500;
            coef_cnt_reg <= 3'd7;
            coef_reg[0]  <= '0;
            coef_reg[1]  <= '0;
            coef_reg[2]  <= '0;
            coef6_reg    <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (msadpcm_pkg::cfg_index_t'(cfg_index))
                msadpcm_pkg::CFG_CHANNEL_COUNT:     chan_cnt_reg <= cfg_data[1:0];
                msadpcm_pkg::CFG_SAMPLES_PER_BLOCK: spb_reg      <= cfg_data[13:0];
                msadpcm_pkg::CFG_COEF_COUNT:        coef_cnt_reg <= cfg_data[2:0];
                msadpcm_pkg::CFG_COEF_SETS_0_1:     coef_reg[0]  <= cfg_data;
                msadpcm_pkg::CFG_COEF_SETS_2_3:     coef_reg[1]  <= cfg_data;
                msadpcm_pkg::CFG_COEF_SETS_4_5:     coef_reg[2]  <= cfg_data;
                msadpcm_pkg::CFG_COEF_SET_6:        coef6_reg    <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pred_reg     <= '{default: '0};
            step_reg     <= '{default: '0};
            h1_reg       <= '{default: '0};
            h2_reg       <= '{default: '0};
            hbc_reg      <= '0;
            rem_reg      <= '0;
            low_reg      <= '0;
            bad_reg      <= '0;
            active_reg   <= 1'b0;
            stereo_reg   <= 1'b0;
            in_valid_reg <= 1'b0;
            ph_reg       <= '0;
            last_k_reg   <= '0;
            hdr_item_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            pred_reg   <= pred_next;
            step_reg   <= step_next;
            h1_reg     <= h1_next;
            h2_reg     <= h2_next;
            hbc_reg    <= hbc_next;
            rem_reg    <= rem_next;
            low_reg    <= low_next;
            bad_reg    <= bad_next;
            active_reg <= active_next;
            stereo_reg <= stereo_next;
            ph_reg     <= ph_next;

            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (step_en && ph_reg == 2'd0) begin
                last_k_reg   <= n0[1:0] - 2'd1;
                hdr_item_reg <= in_header;
            end

            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser[0];
        end
        if (emit) begin
            m_pcm_reg  <= res_pcm;
            m_ch_reg   <= res_ch;
            m_hdr_reg  <= !data_res;
            m_bad_reg  <= bad_reg[res_ch];
            m_last_reg <= res_last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_pcm_reg;
    assign m_axis_tuser  = {m_bad_reg, m_hdr_reg, m_ch_reg};
    assign m_axis_tlast  = m_last_reg;

    // ------------------------------------------------------------ assertions
    `MSADPCM_ASSERT_IMPL(a_phase_has_item, aclk, aresetn, ph_reg != 2'd0, in_valid_reg)
    `MSADPCM_ASSERT_IMPL(a_phase_in_range, aclk, aresetn, ph_reg != 2'd0, ph_reg <= last_k_reg)
    `MSADPCM_ASSERT_IMPL(a_hdr_last_chan, aclk, aresetn,
        m_valid_reg && m_last_reg && m_hdr_reg, m_ch_reg == stereo_reg)
    `MSADPCM_ASSERT_NEXT(a_idle_no_result, aclk, aresetn,
        step_en && ph_reg == 2'd0 && !active_eff, !m_valid_reg)

endmodule
